FILE: rtl/core/positional_array_list_unit_defines.svh
// Assertion macros shared by the positional array list RTL.
`ifndef POSITIONAL_ARRAY_LIST_UNIT_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PAL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PAL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pal_pkg.sv
// Shared constants and types for the positional array list.
`timescale 1ns / 1ps

package pal_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int DATA_W   = 32;
  localparam int CNT_W    = 6;
  localparam int OP_W     = 3;

  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd3;
  localparam logic [OP_W-1:0] OP_LIST   = 3'd4;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_e;

  typedef struct packed {
    cell_op_e                 op;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] data;
  } cell_cmd_t;

endpackage

FILE: rtl/core/pal_cell.sv
// One list cell: holds an entry and takes from a neighbor on shift or rotate.
`timescale 1ns / 1ps

module pal_cell (
  input  logic                             clk_i,
  input  logic [pal_pkg::IDX_W-1:0]        idx_i,
  input  pal_pkg::cell_cmd_t               cmd_i,
  input  logic signed [pal_pkg::DATA_W-1:0] left_i,
  input  logic signed [pal_pkg::DATA_W-1:0] right_i,
  output logic signed [pal_pkg::DATA_W-1:0] data_o
);

  logic signed [pal_pkg::DATA_W-1:0] data_q;
  logic signed [pal_pkg::DATA_W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    case (cmd_i.op)
      pal_pkg::CELL_WRITE: begin
        if (idx_i == cmd_i.idx) data_d = cmd_i.data;
      end
      pal_pkg::CELL_INSERT: begin
        if (idx_i == cmd_i.idx) data_d = cmd_i.data;
        else if (idx_i > cmd_i.idx) data_d = left_i;
      end
      pal_pkg::CELL_DELETE: begin
        if (idx_i >= cmd_i.idx) data_d = right_i;
      end
      pal_pkg::CELL_ROTATE: begin
        data_d = right_i;
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

FILE: rtl/core/pal_chain.sv
// Row of list cells closed into a ring; cell 0 is the read head.
`timescale 1ns / 1ps

module pal_chain (
  input  logic                              clk_i,
  input  pal_pkg::cell_cmd_t                cmd_i,
  output logic signed [pal_pkg::DATA_W-1:0] head_o
);

  logic signed [pal_pkg::DATA_W-1:0] cell_data [pal_pkg::CAPACITY];

  for (genvar i = 0; i < pal_pkg::CAPACITY; i++) begin : g_cell
    pal_cell u_cell (
      .clk_i  (clk_i),
      .idx_i  (pal_pkg::IDX_W'(i)),
      .cmd_i  (cmd_i),
      .left_i (cell_data[(i + pal_pkg::CAPACITY - 1) % pal_pkg::CAPACITY]),
      .right_i(cell_data[(i + 1) % pal_pkg::CAPACITY]),
      .data_o (cell_data[i])
    );
  end

  assign head_o = cell_data[0];

endmodule

FILE: rtl/core/positional_array_list_unit.sv
// Top level of the positional array list: command control, scan and result register.
`timescale 1ns / 1ps
`include "positional_array_list_unit_defines.svh"

// Positional array list unit. Holds up to 32 signed 32-bit entries in a ring
// of cells, addressed by 1-based position. Append, insert and delete are
// each done in the cycle that takes them: every cell compares its own index
// with the broadcast position and loads the new value, its left neighbor
// (insert) or its right neighbor (delete) at once, and the single result is
// ready in the output register in the next cycle. Search and list walk the
// ring: whenever the output register is free, the whole ring rotates by one
// cell per cycle past a single head comparator, for a full turn of 32 steps
// so the contents end where they began, then a done state flushes the final
// result. Results of search and list come out in ascending position order,
// with last set on the final one; a search with no match and a list of an
// empty list give one result with ok clear. No new command is taken while a
// scan runs. Entries past the fill level are never reported, so they need no
// clearing after reset.
module positional_array_list_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [pal_pkg::OP_W-1:0]          op_i,
  input  logic signed [pal_pkg::DATA_W-1:0] data_in_i,
  input  logic [pal_pkg::CNT_W-1:0]         pos_in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              ok_o,
  output logic signed [pal_pkg::DATA_W-1:0] data_out_o,
  output logic [pal_pkg::CNT_W-1:0]         pos_out_o,
  output logic [pal_pkg::CNT_W-1:0]         count_o,
  output logic                              last_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam logic [pal_pkg::CNT_W-1:0] FULL = pal_pkg::CNT_W'(pal_pkg::CAPACITY);
  localparam logic [pal_pkg::IDX_W-1:0] SCAN_END = pal_pkg::IDX_W'(pal_pkg::CAPACITY - 1);

  logic [1:0]                        state_q, state_d;
  logic [pal_pkg::CNT_W-1:0]         fill_q, fill_d;
  logic [pal_pkg::IDX_W-1:0]         scan_cnt_q, scan_cnt_d;
  logic                              list_q, list_d;
  logic signed [pal_pkg::DATA_W-1:0] key_q, key_d;

  // Pending scan hit: held back until we know whether it is the final one.
  logic                              pend_valid_q, pend_valid_d;
  logic signed [pal_pkg::DATA_W-1:0] pend_data_q, pend_data_d;
  logic [pal_pkg::CNT_W-1:0]         pend_pos_q, pend_pos_d;

  // Output register.
  logic                              out_valid_q, out_valid_d;
  logic                              ok_q, ok_d;
  logic signed [pal_pkg::DATA_W-1:0] data_out_q, data_out_d;
  logic [pal_pkg::CNT_W-1:0]         pos_out_q, pos_out_d;
  logic [pal_pkg::CNT_W-1:0]         count_q, count_d;
  logic                              last_q, last_d;

  pal_pkg::cell_cmd_t                cell_cmd;
  logic signed [pal_pkg::DATA_W-1:0] head;

  logic                       out_free;
  logic                       accept;
  logic                       scan_step;
  logic                       scan_wrap;
  logic                       hit;
  logic [pal_pkg::CNT_W:0]    fill_plus1;
  logic                       ins_ok;
  logic                       del_ok;
  logic                       app_ok;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;
  assign scan_step  = (state_q == S_SCAN) && out_free;
  assign scan_wrap  = scan_step && (scan_cnt_q == SCAN_END);

  assign fill_plus1 = {1'b0, fill_q} + (pal_pkg::CNT_W + 1)'(1);
  assign app_ok     = fill_q < FULL;
  assign ins_ok     = (pos_in_i != '0) && ({1'b0, pos_in_i} <= fill_plus1) && app_ok;
  assign del_ok     = (pos_in_i != '0) && (pos_in_i <= fill_q);

  // Head cell holds entry scan_cnt_q while the ring turns.
  assign hit = (pal_pkg::CNT_W'(scan_cnt_q) < fill_q) && (list_q || (head == key_q));

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    scan_cnt_d   = scan_cnt_q;
    list_d       = list_q;
    key_d        = key_q;
    pend_valid_d = pend_valid_q;
    pend_data_d  = pend_data_q;
    pend_pos_d   = pend_pos_q;

    out_valid_d = out_valid_q && out_stall_i;
    ok_d        = ok_q;
    data_out_d  = data_out_q;
    pos_out_d   = pos_out_q;
    count_d     = count_q;
    last_d      = last_q;

    cell_cmd.op   = pal_pkg::CELL_HOLD;
    cell_cmd.idx  = pos_in_i[pal_pkg::IDX_W-1:0] - pal_pkg::IDX_W'(1);
    cell_cmd.data = data_in_i;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_valid_d = 1'b1;
          ok_d        = 1'b0;
          data_out_d  = '0;
          pos_out_d   = '0;
          count_d     = fill_q;
          last_d      = 1'b1;
          case (op_i)
            pal_pkg::OP_APPEND: begin
              if (app_ok) begin
                cell_cmd.op  = pal_pkg::CELL_WRITE;
                cell_cmd.idx = fill_q[pal_pkg::IDX_W-1:0];
                fill_d       = fill_q + pal_pkg::CNT_W'(1);
                ok_d         = 1'b1;
                count_d      = fill_d;
              end
            end
            pal_pkg::OP_INSERT: begin
              if (ins_ok) begin
                cell_cmd.op = pal_pkg::CELL_INSERT;
                fill_d      = fill_q + pal_pkg::CNT_W'(1);
                ok_d        = 1'b1;
                count_d     = fill_d;
              end
            end
            pal_pkg::OP_DELETE: begin
              if (del_ok) begin
                cell_cmd.op = pal_pkg::CELL_DELETE;
                fill_d      = fill_q - pal_pkg::CNT_W'(1);
                ok_d        = 1'b1;
                count_d     = fill_d;
              end
            end
            pal_pkg::OP_SEARCH, pal_pkg::OP_LIST: begin
              // Results come from the scan; nothing goes out now.
              out_valid_d  = 1'b0;
              state_d      = S_SCAN;
              scan_cnt_d   = '0;
              list_d       = (op_i == pal_pkg::OP_LIST);
              key_d        = data_in_i;
              pend_valid_d = 1'b0;
            end
            default: begin
              ok_d = 1'b0;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_step) begin
          cell_cmd.op = pal_pkg::CELL_ROTATE;
          scan_cnt_d  = scan_cnt_q + pal_pkg::IDX_W'(1);
          if (hit) begin
            // Release the previous hit; it is known not to be the final one.
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              ok_d        = 1'b1;
              data_out_d  = pend_data_q;
              pos_out_d   = pend_pos_q;
              count_d     = fill_q;
              last_d      = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_data_d  = list_q ? head : '0;
            pend_pos_d   = pal_pkg::CNT_W'(scan_cnt_q) + pal_pkg::CNT_W'(1);
          end
          if (scan_cnt_q == SCAN_END) begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          ok_d        = pend_valid_q;
          data_out_d  = pend_valid_q ? pend_data_q : '0;
          pos_out_d   = pend_valid_q ? pend_pos_q : '0;
          count_d     = fill_q;
          last_d      = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fill_q       <= '0;
      scan_cnt_q   <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      fill_q       <= fill_d;
      scan_cnt_q   <= scan_cnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    list_q      <= list_d;
    key_q       <= key_d;
    pend_data_q <= pend_data_d;
    pend_pos_q  <= pend_pos_d;
    ok_q        <= ok_d;
    data_out_q  <= data_out_d;
    pos_out_q   <= pos_out_d;
    count_q     <= count_d;
    last_q      <= last_d;
  end

  pal_chain u_chain (
    .clk_i (clk_i),
    .cmd_i (cell_cmd),
    .head_o(head)
  );

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign data_out_o  = data_out_q;
  assign pos_out_o   = pos_out_q;
  assign count_o     = count_q;
  assign last_o      = last_q;

  `PAL_ASSERT_IMP(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= FULL, "fill above capacity")
  `PAL_ASSERT_IMP(a_take_idle, clk_i, rst_ni, !in_stall_o, state_q == S_IDLE, "taken mid-scan")
  `PAL_ASSERT_NXT(a_scan_end, clk_i, rst_ni, scan_wrap, state_q == S_DONE, "scan did not stop")
  `PAL_ASSERT_NXT(a_fill_hold, clk_i, rst_ni, state_q != S_IDLE, $stable(fill_q), "fill moved")

endmodule
